FILE: rtl/periodic_pair_distance_top_defines.svh
// Assertion macros used by the RTL that checks itself.
`ifndef PERIODIC_PAIR_DISTANCE_TOP_DEFINES_SVH
`define PERIODIC_PAIR_DISTANCE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PPD_ASSERT(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define PPD_ASSERT_IMP(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

FILE: rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Widths, register indexes and pipeline payload types for the pair distance.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

   localparam int COORD_W   = 24;                 // Q8.16 coordinate
   localparam int FRAC_BITS = 16;                 // fraction bits of sine/cosine
   localparam int DIFF_W    = COORD_W + 2;        // signed image difference
   localparam int MAG_W     = COORD_W + 1;        // image difference magnitude
   localparam int SQR_W     = 2 * MAG_W;          // one squared component
   localparam int SUM_W     = SQR_W + 1;          // dx^2 + dy^2
   localparam int LIM_W     = 2 * COORD_W;        // threshold squared
   localparam int ROOT_W    = COORD_W;            // distance of a neighbor
   localparam int QBITS     = FRAC_BITS + 1;      // quotient bits, ratio <= 1.0
   localparam int DIST_W    = 26;
   localparam int TRIG_W    = 18;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = CSR_IDX_W'(1);

   // Winning image data that rides along the square root and divider.
   typedef struct packed {
      logic               hit;
      logic [COORD_W-1:0] mag_x;
      logic [COORD_W-1:0] mag_y;
      logic               neg_x;
      logic               neg_y;
   } side_type;

   typedef struct packed {
      logic [LIM_W-1:0] sq;
      side_type         side;
   } sqrt_in_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      side_type          side;
   } sqrt_out_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic [QBITS-1:0]  q_x;
      logic [QBITS-1:0]  q_y;
      side_type          side;
   } div_out_type;

endpackage

`default_nettype wire

FILE: rtl/ppd_sqrt.sv
// ----------------------------------------------------------------------------
// ppd_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_sqrt (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  ppd_pkg::sqrt_in_type  in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output ppd_pkg::sqrt_out_type out_data
);

   localparam int STEPS = ppd_pkg::ROOT_W;
   localparam int W     = ppd_pkg::LIM_W;

   logic                 v_ff    [STEPS];
   logic [W-1:0]         rem_ff  [STEPS];
   logic [W-1:0]         res_ff  [STEPS];
   ppd_pkg::side_type    side_ff [STEPS];
   logic [W-1:0]         rem_in  [STEPS];
   logic [W-1:0]         res_in  [STEPS];
   logic                 adv;

   // Stall the whole chain only when the last stage cannot hand off
   assign adv      = !v_ff[STEPS-1] || out_ready;
   assign in_ready = adv;

   // One digit step per stage
   always_comb begin
      logic [W-1:0] src_rem;
      logic [W-1:0] src_res;
      logic [W-1:0] bitv;
      logic [W-1:0] trial;
      for (int i = 0; i < STEPS; i++) begin
         src_rem = (i == 0) ? in_data.sq : rem_ff[(i == 0) ? 0 : i-1];
         src_res = (i == 0) ? '0         : res_ff[(i == 0) ? 0 : i-1];
         bitv    = W'(1) << (W - 2 - 2 * i);
         trial   = src_res + bitv;
         if (src_rem >= trial) begin
            rem_in[i] = src_rem - trial;
            res_in[i] = (src_res >> 1) + bitv;
         end else begin
            rem_in[i] = src_rem;
            res_in[i] = src_res >> 1;
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEPS; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < STEPS; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_data.side;
         for (int i = 1; i < STEPS; i++) side_ff[i] <= side_ff[i-1];
         for (int i = 0; i < STEPS; i++) begin
            rem_ff[i] <= rem_in[i];
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign out_valid     = v_ff[STEPS-1];
   assign out_data.root = res_ff[STEPS-1][ppd_pkg::ROOT_W-1:0];
   assign out_data.side = side_ff[STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/ppd_div.sv
// ----------------------------------------------------------------------------
// ppd_div
// Pipelined restoring divider for both ratios, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_div (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  ppd_pkg::sqrt_out_type in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output ppd_pkg::div_out_type  out_data
);

   localparam int STEPS = ppd_pkg::QBITS;
   localparam int CW    = ppd_pkg::COORD_W;
   localparam int NW    = CW + ppd_pkg::FRAC_BITS;

   logic                 v_ff    [STEPS];
   logic [CW-1:0]        rx_ff   [STEPS];
   logic [CW-1:0]        ry_ff   [STEPS];
   logic [STEPS-1:0]     qx_ff   [STEPS];
   logic [STEPS-1:0]     qy_ff   [STEPS];
   logic [CW-1:0]        d_ff    [STEPS];
   ppd_pkg::side_type    side_ff [STEPS];
   logic [CW-1:0]        rx_in   [STEPS];
   logic [CW-1:0]        ry_in   [STEPS];
   logic [STEPS-1:0]     qx_in   [STEPS];
   logic [STEPS-1:0]     qy_in   [STEPS];
   logic                 adv;

   assign adv      = !v_ff[STEPS-1] || out_ready;
   assign in_ready = adv;

   // Shift in one numerator bit, subtract the divisor where it fits
   always_comb begin
      ppd_pkg::side_type s;
      logic [CW-1:0]     d;
      logic [CW-1:0]     rx;
      logic [CW-1:0]     ry;
      logic [STEPS-1:0]  qx;
      logic [STEPS-1:0]  qy;
      logic [NW-1:0]     nx;
      logic [NW-1:0]     ny;
      logic [CW:0]       tx;
      logic [CW:0]       ty;
      for (int j = 0; j < STEPS; j++) begin
         s  = (j == 0) ? in_data.side : side_ff[(j == 0) ? 0 : j-1];
         d  = (j == 0) ? in_data.root : d_ff[(j == 0) ? 0 : j-1];
         nx = {s.mag_x, ppd_pkg::FRAC_BITS'(0)};
         ny = {s.mag_y, ppd_pkg::FRAC_BITS'(0)};
         rx = (j == 0) ? CW'(nx >> STEPS) : rx_ff[(j == 0) ? 0 : j-1];
         ry = (j == 0) ? CW'(ny >> STEPS) : ry_ff[(j == 0) ? 0 : j-1];
         qx = (j == 0) ? '0 : qx_ff[(j == 0) ? 0 : j-1];
         qy = (j == 0) ? '0 : qy_ff[(j == 0) ? 0 : j-1];
         tx = {rx, nx[STEPS-1-j]};
         ty = {ry, ny[STEPS-1-j]};
         if (tx >= {1'b0, d}) begin
            rx_in[j] = CW'(tx - {1'b0, d});
            qx_in[j] = {qx[STEPS-2:0], 1'b1};
         end else begin
            rx_in[j] = CW'(tx);
            qx_in[j] = {qx[STEPS-2:0], 1'b0};
         end
         if (ty >= {1'b0, d}) begin
            ry_in[j] = CW'(ty - {1'b0, d});
            qy_in[j] = {qy[STEPS-2:0], 1'b1};
         end else begin
            ry_in[j] = CW'(ty);
            qy_in[j] = {qy[STEPS-2:0], 1'b0};
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < STEPS; j++) v_ff[j] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int j = 1; j < STEPS; j++) v_ff[j] <= v_ff[j-1];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_data.side;
         d_ff[0]    <= in_data.root;
         for (int j = 1; j < STEPS; j++) begin
            side_ff[j] <= side_ff[j-1];
            d_ff[j]    <= d_ff[j-1];
         end
         for (int j = 0; j < STEPS; j++) begin
            rx_ff[j] <= rx_in[j];
            ry_ff[j] <= ry_in[j];
            qx_ff[j] <= qx_in[j];
            qy_ff[j] <= qy_in[j];
         end
      end
   end

   assign out_valid     = v_ff[STEPS-1];
   assign out_data.root = d_ff[STEPS-1];
   assign out_data.q_x  = qx_ff[STEPS-1];
   assign out_data.q_y  = qy_ff[STEPS-1];
   assign out_data.side = side_ff[STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/periodic_pair_distance_top.sv
// ----------------------------------------------------------------------------
// periodic_pair_distance_top
// Minimum-image distance, sine and cosine between two agents in a periodic box.
// ----------------------------------------------------------------------------
// A new pair transfers in every cycle while the response side keeps up. Each
// result passes three front stages (image differences, squares, neighbor test
// and image select), 24 square root stages, 17 divider stages and one output
// register. A stalled response holds the whole pipeline in place. Configuration
// writes are taken at once and must come while idle.
`default_nettype none
`include "periodic_pair_distance_top_defines.svh"

module periodic_pair_distance_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [ppd_pkg::COORD_W-1:0]        req_first_x,
   input  wire  [ppd_pkg::COORD_W-1:0]        req_first_y,
   input  wire  [ppd_pkg::COORD_W-1:0]        req_second_x,
   input  wire  [ppd_pkg::COORD_W-1:0]        req_second_y,
   input  wire                                req_edge_flag,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [ppd_pkg::DIST_W-1:0]         rsp_distance_out,
   output logic signed [ppd_pkg::TRIG_W-1:0]  rsp_sine_out,
   output logic signed [ppd_pkg::TRIG_W-1:0]  rsp_cosine_out,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [ppd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [ppd_pkg::COORD_W-1:0]        csr_wdata
);

   localparam int CW = ppd_pkg::COORD_W;
   localparam int DW = ppd_pkg::DIFF_W;
   localparam int MW = ppd_pkg::MAG_W;
   localparam int QW = ppd_pkg::SQR_W;
   localparam int SW = ppd_pkg::SUM_W;
   localparam int LW = ppd_pkg::LIM_W;
   localparam int TW = ppd_pkg::TRIG_W;

   // Configuration
   logic [CW-1:0] period_ff;
   logic [CW-1:0] thr_ff;
   logic [LW-1:0] thr_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         thr_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ppd_pkg::CSR_PERIOD:    period_ff <= csr_wdata;
            ppd_pkg::CSR_THRESHOLD: thr_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Keep the squared threshold tracking the register
   always_ff @(posedge clock) begin
      thr_sq_ff <= thr_ff * thr_ff;
   end

   // Front pipeline control
   logic front_adv;
   logic sq_in_ready;
   logic s1_v_ff, s2_v_ff, s3_v_ff;

   assign front_adv = !s3_v_ff || sq_in_ready;
   assign req_ready = front_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (front_adv) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // Stage 1: image differences as magnitude and sign
   // index 0 direct, 1 first shifted by +period, 2 by -period
   logic signed [DW-1:0] dx_in [3];
   logic signed [DW-1:0] dy_in [3];
   logic [MW-1:0] mx1_ff [3];
   logic [MW-1:0] my1_ff [3];
   logic          nx1_ff [3];
   logic          ny1_ff [3];
   logic          edge1_ff;

   always_comb begin
      logic signed [DW-1:0] bx;
      logic signed [DW-1:0] by;
      logic signed [DW-1:0] pp;
      bx = $signed({2'b00, req_second_x}) - $signed({2'b00, req_first_x});
      by = $signed({2'b00, req_second_y}) - $signed({2'b00, req_first_y});
      pp = $signed({2'b00, period_ff});
      dx_in[0] = bx;
      dx_in[1] = bx - pp;
      dx_in[2] = bx + pp;
      dy_in[0] = by;
      dy_in[1] = by - pp;
      dy_in[2] = by + pp;
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         edge1_ff <= req_edge_flag;
         for (int k = 0; k < 3; k++) begin
            nx1_ff[k] <= dx_in[k][DW-1];
            ny1_ff[k] <= dy_in[k][DW-1];
            mx1_ff[k] <= dx_in[k][DW-1] ? MW'(-dx_in[k]) : MW'(dx_in[k]);
            my1_ff[k] <= dy_in[k][DW-1] ? MW'(-dy_in[k]) : MW'(dy_in[k]);
         end
      end
   end

   // Stage 2: square every component
   logic [QW-1:0] sx2_ff [3];
   logic [QW-1:0] sy2_ff [3];
   logic [MW-1:0] mx2_ff [3];
   logic [MW-1:0] my2_ff [3];
   logic          nx2_ff [3];
   logic          ny2_ff [3];
   logic          edge2_ff;

   always_ff @(posedge clock) begin
      if (front_adv) begin
         edge2_ff <= edge1_ff;
         for (int k = 0; k < 3; k++) begin
            sx2_ff[k] <= mx1_ff[k] * mx1_ff[k];
            sy2_ff[k] <= my1_ff[k] * my1_ff[k];
            mx2_ff[k] <= mx1_ff[k];
            my2_ff[k] <= my1_ff[k];
            nx2_ff[k] <= nx1_ff[k];
            ny2_ff[k] <= ny1_ff[k];
         end
      end
   end

   // Stage 3: neighbor test on the five images, first match wins
   ppd_pkg::sqrt_in_type s3_in;
   ppd_pkg::sqrt_in_type s3_ff;

   always_comb begin
      logic [SW-1:0] sum [5];
      logic          ok  [5];
      logic [1:0]    ix  [5];
      logic [1:0]    iy  [5];
      logic [2:0]    w;
      ix[0] = 2'd0; iy[0] = 2'd0;
      ix[1] = 2'd1; iy[1] = 2'd0;
      ix[2] = 2'd2; iy[2] = 2'd0;
      ix[3] = 2'd0; iy[3] = 2'd1;
      ix[4] = 2'd0; iy[4] = 2'd2;
      for (int m = 0; m < 5; m++) begin
         sum[m] = SW'(sx2_ff[ix[m]]) + SW'(sy2_ff[iy[m]]);
         ok[m]  = (sum[m] < SW'(thr_sq_ff)) && ((m == 0) || edge2_ff);
      end
      w = 3'd0;
      for (int m = 4; m >= 0; m--) begin
         if (ok[m]) w = 3'(m);
      end
      s3_in.sq         = LW'(sum[w]);
      s3_in.side.hit   = ok[0] || ok[1] || ok[2] || ok[3] || ok[4];
      s3_in.side.mag_x = CW'(mx2_ff[ix[w]]);
      s3_in.side.mag_y = CW'(my2_ff[iy[w]]);
      s3_in.side.neg_x = nx2_ff[ix[w]];
      s3_in.side.neg_y = ny2_ff[iy[w]];
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         s3_ff <= s3_in;
      end
   end

   // Square root and ratio pipelines
   logic                  sq_out_valid;
   logic                  div_in_ready;
   ppd_pkg::sqrt_out_type sq_out;
   logic                  div_out_valid;
   logic                  rsp_adv;
   ppd_pkg::div_out_type  div_out;

   ppd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_ready  (sq_in_ready),
      .in_data   (s3_ff),
      .out_valid (sq_out_valid),
      .out_ready (div_in_ready),
      .out_data  (sq_out)
   );

   ppd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_out_valid),
      .in_ready  (div_in_ready),
      .in_data   (sq_out),
      .out_valid (div_out_valid),
      .out_ready (rsp_adv),
      .out_data  (div_out)
   );

   // Output register: pick neighbor result, all zero for a zero distance, or fallback
   logic                       rsp_valid_ff;
   logic [ppd_pkg::DIST_W-1:0] dist_ff;
   logic signed [TW-1:0]       sine_ff;
   logic signed [TW-1:0]       cosine_ff;
   logic [ppd_pkg::DIST_W-1:0] dist_in;
   logic signed [TW-1:0]       sine_in;
   logic signed [TW-1:0]       cosine_in;

   assign rsp_adv = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic signed [TW-1:0] qx;
      logic signed [TW-1:0] qy;
      qx = $signed(TW'(div_out.q_x));
      qy = $signed(TW'(div_out.q_y));
      if (!div_out.side.hit) begin
         dist_in   = {1'b0, thr_ff, 1'b0};
         sine_in   = '0;
         cosine_in = '0;
      end else if (div_out.root == '0) begin
         dist_in   = '0;
         sine_in   = '0;
         cosine_in = '0;
      end else begin
         dist_in   = ppd_pkg::DIST_W'(div_out.root);
         sine_in   = div_out.side.neg_y ? -qy : qy;
         cosine_in = div_out.side.neg_x ? -qx : qx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_adv) begin
         dist_ff   <= dist_in;
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance_out = dist_ff;
   assign rsp_sine_out     = sine_ff;
   assign rsp_cosine_out   = cosine_ff;

   // Checks
   `PPD_ASSERT_IMP(a_stall_source, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled without a held response")
   `PPD_ASSERT_IMP(a_sine_range, clock, reset, rsp_valid, (rsp_sine_out >= -65536) && (rsp_sine_out <= 65536), "sine out of unit range")
   `PPD_ASSERT_IMP(a_trig_needs_dist, clock, reset, rsp_valid && ((rsp_sine_out != 0) || (rsp_cosine_out != 0)), rsp_distance_out != 0, "nonzero ratio with zero distance")

endmodule

`default_nettype wire
